@@ rtl/ws_enc_pkg.sv @@
// ----------------------------------------------------------------------------
// ws_enc_pkg
// Shared types, register indexes and the channel scaling function of the
// LED bit slot encoder.
// ----------------------------------------------------------------------------
package ws_enc_pkg;

    localparam int CHANNEL_BITS    = 8;
    localparam int PIXEL_SLOTS     = 3 * CHANNEL_BITS;
    localparam int MAX_RESET_SLOTS = 64;
    localparam int SLOT_CNT_W      = 7;
    localparam int DUTY_W          = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 8;

    localparam logic [DUTY_W-1:0]       ONE_DUTY_RST    = 8'd38;
    localparam logic [DUTY_W-1:0]       ZERO_DUTY_RST   = 8'd19;
    localparam logic [SLOT_CNT_W-1:0]   RESET_SLOTS_RST = 7'd50;
    localparam logic [CHANNEL_BITS-1:0] BRIGHTNESS_RST  = 8'd100;

    localparam logic [CFG_IDX_W-1:0] CFG_ONE_DUTY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_DUTY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_SLOTS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS  = 2'd3;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_LATCH = 1'b1;

    typedef struct packed {
        logic                    operation;
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } t_pixel_in;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              last_slot;
    } t_slot_out;

    // Floor of value * scale / 255, using the exact 16-bit reciprocal form.
    function automatic logic [CHANNEL_BITS-1:0] scale_channel(
        input logic [CHANNEL_BITS-1:0] value,
        input logic [CHANNEL_BITS-1:0] scale
    );
        logic [2*CHANNEL_BITS-1:0] prod;
        logic [2*CHANNEL_BITS:0]   sum;
        prod = value * scale;
        sum  = {1'b0, prod} + {{(CHANNEL_BITS+1){1'b0}}, prod[2*CHANNEL_BITS-1:CHANNEL_BITS]}
             + {{(2*CHANNEL_BITS){1'b0}}, 1'b1};
        return sum[2*CHANNEL_BITS-1:CHANNEL_BITS];
    endfunction

endpackage

@@ rtl/ws2812_bit_slot_encoder.sv @@
// ----------------------------------------------------------------------------
// ws2812_bit_slot_encoder
// Turns pixel and latch words into a stream of per-bit PWM duty words.
// ----------------------------------------------------------------------------
//  Channel  | Ports                                   | Word
//  ---------+-----------------------------------------+-------------------
//  input    | i_in_valid, o_in_ready, i_in_data       | pixel or latch
//  output   | o_out_valid, i_out_ready, o_out_data    | one duty slot
//  config   | i_cfg_wr_en, i_cfg_index, i_cfg_data    | register write
//
// One slot leaves per cycle: a pixel gives 24 slots and a latch its reset
// length, 1 to 64 slots, from r_reset_slots. A queued word loads as the last
// slot of the previous one goes out, so runs follow with no gap. The first
// slot passes the input register and the emitter before the output register.
// Reset is synchronous and restores the register defaults. A stalled output
// holds the emitter and, once the input register is full, the input.
// ----------------------------------------------------------------------------
module ws2812_bit_slot_encoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ws_enc_pkg::t_pixel_in               i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ws_enc_pkg::t_slot_out               o_out_data,
    input  logic                                i_cfg_wr_en,
    input  logic [ws_enc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ws_enc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ws_enc_pkg::*;

    logic [DUTY_W-1:0]       r_one_duty;
    logic [DUTY_W-1:0]       r_zero_duty;
    logic [SLOT_CNT_W-1:0]   r_reset_slots;
    logic [CHANNEL_BITS-1:0] r_brightness;

    logic                    r_in_valid;
    t_pixel_in               r_in;

    logic [PIXEL_SLOTS-1:0]  r_shift, n_shift;
    logic [SLOT_CNT_W-1:0]   r_left, n_left;
    logic                    r_run, n_run;

    logic                    r_out_valid, n_out_valid;
    t_slot_out               r_out, n_out;

    logic                    out_free;
    logic                    emit;
    logic                    load;
    logic [SLOT_CNT_W-1:0]   latch_len;
    logic [CHANNEL_BITS-1:0] red_s, green_s, blue_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_duty    <= ONE_DUTY_RST;
            r_zero_duty   <= ZERO_DUTY_RST;
            r_reset_slots <= RESET_SLOTS_RST;
            r_brightness  <= BRIGHTNESS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ONE_DUTY:    r_one_duty    <= i_cfg_data[DUTY_W-1:0];
                CFG_ZERO_DUTY:   r_zero_duty   <= i_cfg_data[DUTY_W-1:0];
                CFG_RESET_SLOTS: r_reset_slots <= i_cfg_data[SLOT_CNT_W-1:0];
                CFG_BRIGHTNESS:  r_brightness  <= i_cfg_data[CHANNEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign out_free   = !r_out_valid || i_out_ready;
    assign emit       = (r_left != '0) && out_free;
    assign load       = r_in_valid && ((r_left == '0) ||
                        ((r_left == SLOT_CNT_W'(1)) && out_free));
    assign o_in_ready = !r_in_valid || load;

    assign red_s   = scale_channel(r_in.red, r_brightness);
    assign green_s = scale_channel(r_in.green, r_brightness);
    assign blue_s  = scale_channel(r_in.blue, r_brightness);

    always_comb begin
        if (r_reset_slots == '0) begin
            latch_len = SLOT_CNT_W'(1);
        end else if (r_reset_slots > SLOT_CNT_W'(MAX_RESET_SLOTS)) begin
            latch_len = SLOT_CNT_W'(MAX_RESET_SLOTS);
        end else begin
            latch_len = r_reset_slots;
        end
    end

    always_comb begin
        n_shift     = r_shift;
        n_left      = r_left;
        n_run       = r_run;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (emit) begin
            n_out_valid    = 1'b1;
            n_out.duty     = r_run ? '0 : (r_shift[PIXEL_SLOTS-1] ? r_one_duty : r_zero_duty);
            n_out.last_slot = (r_left == SLOT_CNT_W'(1));
            n_shift        = {r_shift[PIXEL_SLOTS-2:0], 1'b0};
            n_left         = r_left - SLOT_CNT_W'(1);
        end
        if (load) begin
            if (r_in.operation == OP_LATCH) begin
                n_shift = '0;
                n_left  = latch_len;
                n_run   = 1'b1;
            end else begin
                n_shift = {green_s, red_s, blue_s};
                n_left  = SLOT_CNT_W'(PIXEL_SLOTS);
                n_run   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_left      <= '0;
            r_run       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_left      <= n_left;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        r_shift <= n_shift;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_left_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= SLOT_CNT_W'(MAX_RESET_SLOTS))
        else $error("slot counter exceeds the longest run");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (r_left == '0 || r_left == SLOT_CNT_W'(1)))
        else $error("new word loaded over a run in progress");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> o_out_valid)
        else $error("emitted slot did not reach the output register");
`endif

endmodule
